### src/mas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

  // field widths
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned MUL_W       = 32;
  localparam int unsigned PROD_W      = 35;
  localparam int unsigned IDX_OUT_W   = 3;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 80;

  // per-cycle moves of the storage cells
  typedef struct packed {
    logic load;   // shift one position down the ring, top takes the new item
    logic rot_a;  // diagonal rotation of the a grid
    logic rot_b;  // linear rotation of the ring copies
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/matrix_add_sub_multiply.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: a_value, b_value
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: row, col, sum, diff, product;
//                                                 tlast: last
//
// a matrix is loaded as DIM*DIM items (one item per cycle), then issued as DIM*DIM
// results, one result per cycle while the output does not stall; no new item is
// taken before the last issue; the ring reads out one position a cycle while issuing
// issued results pass stage 1 (products, sum, diff) and then the output register
// reset clears control only, the storage cells hold nothing defined until loaded
// a stalled output freezes issue and the whole result pipeline; loading resumes
// once the last position is issued, while results may still drain

module matrix_add_sub_multiply #(
  parameter int unsigned DIM = 3
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // a_value [15:0], b_value [31:16]
  input  wire logic [mas_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // row [2:0], col [5:3], sum_value [22:6], diff_value [39:23],
  // product_value [74:40], zero [79:75]
  output logic [mas_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o,
  output logic                                     m_axis_tlast_o
);
  import mas_pkg::*;

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CNT_W = $clog2(CELLS);
  localparam int unsigned IDX_W = $clog2(DIM);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]   r_q, r_d;
  logic [IDX_W-1:0]   c_q, c_d;
  cell_ctrl_t         ctrl;

  logic in_acc;
  logic en;
  logic issue;
  logic last0;

  logic signed [DATA_W-1:0] in_a;
  logic signed [DATA_W-1:0] in_b;

  // storage: grid a for row taps, linear a/b for sum/diff, linear b for column taps
  logic signed [DATA_W-1:0] grid  [CELLS];
  logic signed [DATA_W-1:0] lin_a [CELLS];
  logic signed [DATA_W-1:0] lin_b [CELLS];
  logic signed [DATA_W-1:0] lin_a_top;
  logic signed [DATA_W-1:0] lin_b_top;

  logic signed [DATA_W-1:0] a_row [DIM];
  logic signed [DATA_W-1:0] b_col [DIM];
  logic signed [PROD_W-1:0] dot;

  // stage 1 and output registers
  logic                     s1_valid_q, s1_valid_d;
  logic signed [SUM_W-1:0]  s1_sum_q, s1_diff_q;
  logic [IDX_OUT_W-1:0]     s1_row_q, s1_col_q;
  logic                     s1_last_q;

  logic                     out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0]  out_sum_q, out_diff_q;
  logic signed [PROD_W-1:0] out_prod_q;
  logic [IDX_OUT_W-1:0]     out_row_q, out_col_q;
  logic                     out_last_q;

  assign in_a = s_axis_tdata_i[DATA_W-1:0];
  assign in_b = s_axis_tdata_i[2*DATA_W-1:DATA_W];

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign en              = !out_valid_q || m_axis_tready_i;
  assign issue           = en && (state_q == ST_RUN);
  assign last0           = (r_q == IDX_W'(DIM - 1)) && (c_q == IDX_W'(DIM - 1));

  // sequencer: load count, then row and column of the issued result
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    r_d        = r_q;
    c_d        = c_q;
    ctrl       = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          if (load_cnt_q == CNT_W'(CELLS - 1)) begin
            load_cnt_d = '0;
            r_d        = '0;
            c_d        = '0;
            state_d    = ST_RUN;
          end else begin
            load_cnt_d = load_cnt_q + CNT_W'(1);
          end
        end
      end
      ST_RUN: begin
        if (en) begin
          ctrl.rot_b = 1'b1;
          if (c_q == IDX_W'(DIM - 1)) begin
            c_d        = '0;
            ctrl.rot_a = 1'b1;
            if (r_q == IDX_W'(DIM - 1)) begin
              r_d     = '0;
              state_d = ST_LOAD;
            end else begin
              r_d = r_q + IDX_W'(1);
            end
          end else begin
            c_d = c_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      r_q        <= '0;
      c_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      r_q        <= r_d;
      c_q        <= c_d;
    end
  end

  // top of the linear ring takes the new item on load, wraps cell 0 on rotation
  assign lin_a_top = ctrl.load ? in_a : lin_a[0];
  assign lin_b_top = ctrl.load ? in_b : lin_b[0];

  // after t rotations cell j of the linear ring holds element (j + t) mod CELLS;
  // after r diagonal moves grid cell (i, j) holds a[(i + r) mod DIM][(j + r) mod DIM]
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    localparam int unsigned GI   = j / DIM;
    localparam int unsigned GJ   = j % DIM;
    localparam int unsigned DIAG = ((GI + 1) % DIM) * DIM + ((GJ + 1) % DIM);
    localparam int unsigned NXT  = (j + 1) % CELLS;

    logic signed [DATA_W-1:0] grid_load;
    logic signed [DATA_W-1:0] lin_a_in;
    logic signed [DATA_W-1:0] lin_b_in;

    if (j == CELLS - 1) begin : g_top
      assign grid_load = in_a;
      assign lin_a_in  = lin_a_top;
      assign lin_b_in  = lin_b_top;
    end else begin : g_mid
      assign grid_load = grid[NXT];
      assign lin_a_in  = lin_a[NXT];
      assign lin_b_in  = lin_b[NXT];
    end

    mas_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .grid_load_i (grid_load),
      .grid_diag_i (grid[DIAG]),
      .lin_a_i     (lin_a_in),
      .lin_b_i     (lin_b_in),
      .grid_o      (grid[j]),
      .lin_a_o     (lin_a[j]),
      .lin_b_o     (lin_b[j])
    );
  end

  // row taps pair a[r][(k + r) mod DIM] with b[(k + r) mod DIM][c]
  for (genvar k = 0; k < DIM; k++) begin : g_tap
    assign a_row[k] = grid[k];
    assign b_col[k] = lin_b[k * DIM];
  end

  mas_dot #(
    .DIM (DIM)
  ) u_dot (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a_row),
    .b_i   (b_col),
    .dot_o (dot)
  );

  assign s1_valid_d  = en ? issue : s1_valid_q;
  assign out_valid_d = en ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // cell 0 of the linear ring holds the element at the issued position
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q   <= {lin_a[0][DATA_W-1], lin_a[0]} + {lin_b[0][DATA_W-1], lin_b[0]};
      s1_diff_q  <= {lin_a[0][DATA_W-1], lin_a[0]} - {lin_b[0][DATA_W-1], lin_b[0]};
      s1_row_q   <= IDX_OUT_W'(r_q);
      s1_col_q   <= IDX_OUT_W'(c_q);
      s1_last_q  <= last0;
      out_sum_q  <= s1_sum_q;
      out_diff_q <= s1_diff_q;
      out_prod_q <= dot;
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {
    {(OUT_TDATA_W - 2*IDX_OUT_W - 2*SUM_W - PROD_W){1'b0}},
    out_prod_q, out_diff_q, out_sum_q, out_col_q, out_row_q
  };

  // the final load item starts issue at the first position
  a_load_to_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (load_cnt_q == CNT_W'(CELLS - 1)))
      |=> (state_q == ST_RUN && r_q == '0 && c_q == '0))
    else $error("issue did not start at position zero after the final load item");

  // issuing the last position hands the ring back to loading
  a_run_to_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last0) |=> (state_q == ST_LOAD && load_cnt_q == '0))
    else $error("load did not resume after the last position was issued");

  // an output item only appears behind a valid stage 1 entry
  a_out_from_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("output valid without a stage 1 item");

  // the last flag sits on the bottom right position
  a_last_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o)
      |-> (out_row_q == IDX_OUT_W'(DIM - 1) && out_col_q == IDX_OUT_W'(DIM - 1)))
    else $error("last flag on a position other than the final one");

endmodule

`default_nettype wire

### src/mas_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mas_cell (
  input  wire logic                             clk_i,
  input  wire mas_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic signed [mas_pkg::DATA_W-1:0] grid_load_i,
  input  wire logic signed [mas_pkg::DATA_W-1:0] grid_diag_i,
  input  wire logic signed [mas_pkg::DATA_W-1:0] lin_a_i,
  input  wire logic signed [mas_pkg::DATA_W-1:0] lin_b_i,
  output logic signed [mas_pkg::DATA_W-1:0]      grid_o,
  output logic signed [mas_pkg::DATA_W-1:0]      lin_a_o,
  output logic signed [mas_pkg::DATA_W-1:0]      lin_b_o
);
  import mas_pkg::*;

  logic signed [DATA_W-1:0] grid_q, grid_d;
  logic signed [DATA_W-1:0] lin_a_q, lin_a_d;
  logic signed [DATA_W-1:0] lin_b_q, lin_b_d;

  always_comb begin
    grid_d  = grid_q;
    lin_a_d = lin_a_q;
    lin_b_d = lin_b_q;
    if (ctrl_i.load) begin
      grid_d = grid_load_i;
    end else if (ctrl_i.rot_a) begin
      grid_d = grid_diag_i;
    end
    if (ctrl_i.load || ctrl_i.rot_b) begin
      lin_a_d = lin_a_i;
      lin_b_d = lin_b_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    grid_q  <= grid_d;
    lin_a_q <= lin_a_d;
    lin_b_q <= lin_b_d;
  end

  assign grid_o  = grid_q;
  assign lin_a_o = lin_a_q;
  assign lin_b_o = lin_b_q;

endmodule

`default_nettype wire

### src/mas_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module mas_dot #(
  parameter int unsigned DIM = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [mas_pkg::DATA_W-1:0] a_i [DIM],
  input  wire logic signed [mas_pkg::DATA_W-1:0] b_i [DIM],
  output logic signed [mas_pkg::PROD_W-1:0]      dot_o
);
  import mas_pkg::*;

  logic signed [MUL_W-1:0] prod_q [DIM];

  // one multiplier per tap, registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIM; k++) begin
        prod_q[k] <= MUL_W'(a_i[k]) * MUL_W'(b_i[k]);
      end
    end
  end

  // short add chain over the registered products
  always_comb begin
    dot_o = '0;
    for (int k = 0; k < DIM; k++) begin
      dot_o = dot_o + {{(PROD_W-MUL_W){prod_q[k][MUL_W-1]}}, prod_q[k]};
    end
  end

endmodule

`default_nettype wire
